// ----- src/sssvf_pkg.sv -----
package sssvf_pkg;

    localparam int NORM_BITS  = 30;
    localparam int DIV_STAGES = 32;

    localparam logic [1:0]  AXIS_X     = 2'd0;
    localparam logic [1:0]  AXIS_Y     = 2'd1;
    localparam logic [1:0]  AXIS_Z     = 2'd2;
    localparam logic [31:0] THREE_NORM = 32'd3 << NORM_BITS;

endpackage

// ----- src/sssvf_div.sv -----
module sssvf_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_h,
    input  logic [30:0] i_r,
    output logic [31:0] o_q
);
    import sssvf_pkg::*;

    logic [30:0] r_rem [0:DIV_STAGES-1];
    logic [31:0] r_lo  [0:DIV_STAGES-1];
    logic [30:0] r_div [0:DIV_STAGES-1];
    logic [31:0] r_q   [0:DIV_STAGES];

    assign r_rem[0] = i_h[32:2];
    assign r_lo[0]  = {i_h[1:0], 30'd0};
    assign r_div[0] = i_r;
    assign r_q[0]   = '0;

    // one quotient bit per stage, remainder stays below the divisor
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0] w_sh;
        logic [31:0] w_sub;
        logic        w_ge;

        assign w_sh  = {r_rem[k], r_lo[k][31]};
        assign w_sub = w_sh - {1'b0, r_div[k]};
        assign w_ge  = w_sh >= {1'b0, r_div[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= {r_q[k][30:0], w_ge};
            end
        end

        if (k < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_sub[30:0] : w_sh[30:0];
                    r_lo[k+1]  <= {r_lo[k][30:0], 1'b0};
                    r_div[k+1] <= r_div[k];
                end
            end
        end
    end

    assign o_q = r_q[DIV_STAGES];

endmodule

// ----- src/sssvf_cap.sv -----
module sssvf_cap (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_u,
    output logic [62:0] o_g
);
    import sssvf_pkg::*;

    logic [63:0] w_sq;
    logic [64:0] w_g;
    logic [62:0] r_sq;
    logic [31:0] r_tmu;
    logic [62:0] r_g;

    assign w_sq = 64'(i_u) * 64'(i_u);
    assign w_g  = 65'(r_sq[62:NORM_BITS]) * 65'(r_tmu);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= w_sq[62:0];
            r_tmu <= THREE_NORM - i_u;
            r_g   <= w_g[62:0];
        end
    end

    assign o_g = r_g;

endmodule

// ----- src/sphere_slab_volume_fraction_core.sv -----
// Fraction of a sphere's volume lying between two planes normal to the selected axis
// (0 x, 1 y, 2 z, 3 treated as y). Coordinates are signed Q15.16, radius unsigned
// Q15.16, result unsigned Q1.16 (FRAC_BITS fraction bits) clamped to one; a zero
// radius gives exactly zero or one. One request is taken every cycle unless the output
// is stalled; the pipeline depth is set mainly by the two 32-stage bit-per-stage
// dividers that normalise the cap heights. A stall on the output freezes the whole
// pipeline.
module sphere_slab_volume_fraction_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_center_x,
    input  logic signed [31:0]   i_center_y,
    input  logic signed [31:0]   i_center_z,
    input  logic [30:0]          i_radius,
    input  logic signed [31:0]   i_layer_top,
    input  logic signed [31:0]   i_layer_bottom,
    input  logic [1:0]           i_axis,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FRAC_BITS:0]   o_volume_fraction
);
    import sssvf_pkg::*;

    localparam int VL = DIV_STAGES + 6;
    localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (61 - FRAC_BITS);

    logic en;
    logic r_vld [0:VL-1];
    logic [1:0] r_side [1:VL-1];
    logic r_out_valid;
    logic [FRAC_BITS:0] r_out;

    logic signed [31:0] r_cx, r_cy, r_cz, r_top, r_bot;
    logic [30:0] r_rad0, r_rad1, r_rad2;
    logic [1:0] r_axis;
    logic signed [32:0] r_dt, r_db;
    logic [32:0] r_ht, r_hb;
    logic [31:0] w_qt, w_qb;
    logic [62:0] w_gt, w_gb;
    logic [63:0] r_diff;
    logic r_pos;

    logic signed [31:0] w_c;
    logic signed [32:0] w_r;
    logic [63:0] w_dif, w_sum, w_res;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        case (r_axis)
            AXIS_X:  w_c = r_cx;
            AXIS_Z:  w_c = r_cz;
            default: w_c = r_cy;
        endcase
    end

    assign w_r = 33'(r_rad1);

    function automatic logic [32:0] height(input logic signed [32:0] d,
                                           input logic signed [32:0] r);
        logic signed [33:0] s;
        s = 34'(d) + 34'(r);
        if (d < -r)
            return '0;
        else if (d > r)
            return 33'(34'(r) + 34'(r));
        else
            return s[32:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_cz   <= i_center_z;
            r_top  <= i_layer_top;
            r_bot  <= i_layer_bottom;
            r_rad0 <= i_radius;
            r_axis <= i_axis;
            r_dt   <= 33'(r_top) - 33'(w_c);
            r_db   <= 33'(r_bot) - 33'(w_c);
            r_rad1 <= r_rad0;
            r_ht   <= height(r_dt, w_r);
            r_hb   <= height(r_db, w_r);
            r_rad2 <= r_rad1;
        end
    end

    sssvf_div u_div_top (.i_clk(i_clk), .i_en(en), .i_h(r_ht), .i_r(r_rad2), .o_q(w_qt));
    sssvf_div u_div_bot (.i_clk(i_clk), .i_en(en), .i_h(r_hb), .i_r(r_rad2), .o_q(w_qb));
    sssvf_cap u_cap_top (.i_clk(i_clk), .i_en(en), .i_u(w_qt), .o_g(w_gt));
    sssvf_cap u_cap_bot (.i_clk(i_clk), .i_en(en), .i_u(w_qb), .o_g(w_gb));

    assign w_dif = {1'b0, w_gt} - {1'b0, w_gb};
    assign w_sum = r_diff + HALF;
    assign w_res = w_sum >> (62 - FRAC_BITS);

    // side bits: zero radius, centre within slab
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= {r_rad0 == '0, (r_bot <= w_c) && (w_c <= r_top)};
            for (int k = 2; k < VL; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_diff <= w_dif;
            r_pos  <= w_gt > w_gb;
            if (r_side[VL-1][1])
                r_out <= r_side[VL-1][0] ? ONE[FRAC_BITS:0] : '0;
            else if (!r_pos)
                r_out <= '0;
            else if (w_res > ONE)
                r_out <= ONE[FRAC_BITS:0];
            else
                r_out <= w_res[FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VL; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < VL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[VL-1];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_volume_fraction = r_out;

endmodule

// ----- tb/tb_sphere_slab_volume_fraction_core.sv -----
`timescale 1ns / 100ps

module tb_sphere_slab_volume_fraction_core;
    import sssvf_pkg::*;

    localparam int FB = 16;
    localparam int LATENCY = 39;
    localparam int STALL_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_center_x = '0;
    logic signed [31:0] i_center_y = '0;
    logic signed [31:0] i_center_z = '0;
    logic [30:0]        i_radius = '0;
    logic signed [31:0] i_layer_top = '0;
    logic signed [31:0] i_layer_bottom = '0;
    logic [1:0]         i_axis = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [FB:0]        o_volume_fraction;

    logic [FB:0] fraction_q[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          sink_busy = 1'b0;

    sphere_slab_volume_fraction_core #(.FRAC_BITS(FB)) u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] below_plane(longint d, longint r);
        longint     c;
        logic [63:0] h, u, s;
        c = d;
        if (c < -r) c = -r;
        if (c > r) c = r;
        h = 64'(c + r);
        u = (h << NORM_BITS) / 64'(r);
        if (u > (64'd2 << NORM_BITS)) u = 64'd2 << NORM_BITS;
        s = (u * u) >> NORM_BITS;
        return s * ((64'd3 << NORM_BITS) - u);
    endfunction

    function automatic logic [FB:0] slab_fraction(logic signed [31:0] cx, logic signed [31:0] cy,
            logic signed [31:0] cz, logic [30:0] rad, logic signed [31:0] top,
            logic signed [31:0] bot, logic [1:0] ax);
        longint      c, r;
        logic [63:0] gt, gb, d, res;
        c = (ax == AXIS_X) ? longint'(cx) : (ax == AXIS_Z) ? longint'(cz) : longint'(cy);
        r = longint'(rad);
        if (r == 0)
            return (longint'(bot) <= c && c <= longint'(top)) ? (FB+1)'(1 << FB) : '0;
        gt = below_plane(longint'(top) - c, r);
        gb = below_plane(longint'(bot) - c, r);
        if (gt <= gb) return '0;
        d = gt - gb;
        res = (d + (64'd1 << (61 - FB))) >> (62 - FB);
        if (res > (64'd1 << FB)) res = 64'd1 << FB;
        return res[FB:0];
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_sphere(logic signed [31:0] cx, logic signed [31:0] cy,
            logic signed [31:0] cz, logic [30:0] rad, logic signed [31:0] top,
            logic signed [31:0] bot, logic [1:0] ax, bit gaps = 1'b1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_center_x     <= cx;
        i_center_y     <= cy;
        i_center_z     <= cz;
        i_radius       <= rad;
        i_layer_top    <= top;
        i_layer_bottom <= bot;
        i_axis         <= ax;
        do @(posedge i_clk); while (!o_ready);
        fraction_q = {fraction_q, slab_fraction(cx, cy, cz, rad, top, bot, ax)};
    endtask

    // receiver with random stalls, always ready when sink_busy is clear, or a long hold-off on request
    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
            end else if (sink_busy) begin
                g = gap_len();
                if (g > 0) begin
                    i_ready <= 1'b0;
                    repeat (g - 1) @(posedge i_clk);
                    @(posedge i_clk);
                end
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (fraction_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d", $time,
                         o_volume_fraction);
                n_errors++;
            end else begin
                if (o_volume_fraction !== fraction_q[0]) begin
                    $display("%0t: volume_fraction mismatch, expected %0d, actual %0d",
                             $time, fraction_q[0], o_volume_fraction);
                    n_errors++;
                end
                void'(fraction_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb_sphere_slab_volume_fraction_core: errors");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_sphere(0, 0, 0, 31'd65536, 32'sd65536, -32'sd65536, AXIS_X);
        send_sphere(0, 0, 0, 31'd65536, 32'sd0, -32'sd65536, AXIS_Y);
        send_sphere(0, 0, 0, 31'd65536, 32'sd32768, -32'sd10, AXIS_Z);
        send_sphere(0, 5, 0, 31'd65536, 32'sd20, 32'sd3, 2'd3);
        send_sphere(0, 0, 0, 31'd0, 32'sd0, 32'sd0, AXIS_X);
        send_sphere(1, 0, 0, 31'd0, 32'sd0, -32'sd5, AXIS_X);
        send_sphere(0, 0, mn, 31'd0, mx, mn, AXIS_Z);
        send_sphere(mx, 0, 0, 31'h7fffffff, mx, mn, AXIS_X);
        send_sphere(mn, 0, 0, 31'h7fffffff, mx, mn, AXIS_X);
        send_sphere(mx, mn, mx, 31'h7fffffff, mn, mx, AXIS_Y);
        send_sphere(0, 0, 0, 31'd65536, -32'sd65536, 32'sd65536, AXIS_X);
        send_sphere(0, 0, 0, 31'd100, 32'sd5000, 32'sd200, AXIS_X);
        send_sphere(0, 0, 0, 31'd100, -32'sd200, -32'sd5000, AXIS_X);
        send_sphere(0, 0, 0, 31'd1, 32'sd1, -32'sd1, AXIS_X);
        send_sphere(0, 0, 0, 31'd3, 32'sd1, 32'sd0, AXIS_X);
        send_sphere(32'hffffffff, 0, 0, 31'h55555555, 32'haaaaaaaa, 32'h55555555, AXIS_X);
        send_sphere(32'h55555555, 32'haaaaaaaa, 0, 31'h2aaaaaaa, 32'h55555555,
                    32'haaaaaaaa, AXIS_Y);
    endtask

    task automatic test_random(int n);
        logic signed [31:0] c[3], t, b, lo;
        logic [30:0]        r;
        logic [1:0]         ax;
        repeat (n) begin
            c[0] = rand_coord();
            c[1] = rand_coord();
            c[2] = rand_coord();
            ax = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: r = 31'($urandom);
                1: r = '0;
                2: r = 31'($urandom_range(1, 16));
                default: r = 31'($urandom_range(1, 1 << 22));
            endcase
            if ($urandom_range(0, 9) < 7) begin
                lo = (ax == AXIS_X) ? c[0] : (ax == AXIS_Z) ? c[2] : c[1];
                t = lo + 32'($signed($urandom_range(0, 3 * int'(r[23:0]) + 2)) - int'(r[23:0]));
                b = lo + 32'($signed($urandom_range(0, 3 * int'(r[23:0]) + 2)) - 2 * int'(r[23:0]));
                if ($urandom_range(0, 9) == 0) {t, b} = {b, t};
            end else begin
                t = rand_coord();
                b = rand_coord();
            end
            send_sphere(c[0], c[1], c[2], r, t, b, ax);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(120);
        join
    endtask

    task automatic test_streaming();
        sink_busy = 1'b0;
        repeat (150)
            send_sphere(rand_coord(), rand_coord(), rand_coord(), 31'($urandom_range(0, 1 << 20)),
                        rand_coord(), rand_coord(), 2'($urandom_range(0, 3)), 1'b0);
        sink_busy = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sink_busy = 1'b1;
        test_directed();
        test_random(800);
        test_backpressure();
        test_streaming();
        test_random(150);
        i_valid <= 1'b0;
        while (fraction_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_sphere_slab_volume_fraction_core: clean");
        else
            $display("tb_sphere_slab_volume_fraction_core: errors");
        $finish;
    end

endmodule
